/* rtl/core/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the reversible bounded deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Capacity must be a power of two.
  localparam int CAPACITY = 65536;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = ADDR_W + 1;
  localparam int DATA_W   = 32;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] push_value;
  } rbd_cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
  } rbd_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } rbd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec_push;
    logic exec_pop;
    logic exec_rev;
    logic load_status;
    logic load_data;
  } rbd_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_rev;
    logic full;
    logic empty;
    logic out_free;
  } rbd_sts_t;

endpackage

/* rtl/core/rbd_ram.sv */
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/core/rbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rbd_ctrl
// Command sequencer: accept, execute, read wait.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  rbd_pkg::rbd_sts_t sts,
  output rbd_pkg::rbd_ctl_t ctl
);
  import rbd_pkg::*;

  rbd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_rev) begin
          ctl.exec_rev = 1'b1;
          state_next   = S_IDLE;
        end else if (sts.is_push) begin
          if (!sts.full) begin
            ctl.exec_push = 1'b1;
            state_next    = S_IDLE;
          end else if (sts.out_free) begin
            ctl.load_status = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (sts.is_pop) begin
          if (!sts.empty) begin
            ctl.exec_pop = 1'b1;
            state_next   = S_READ;
          end else if (sts.out_free) begin
            ctl.load_status = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          ctl.load_data = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/rbd_dp.sv */
// ----------------------------------------------------------------------------
// rbd_dp
// Deque datapath: pointers, reverse flag, entry RAM, result register.
// ----------------------------------------------------------------------------
module rbd_dp (
  input  logic              clk,
  input  logic              rst,
  input  rbd_pkg::rbd_cmd_t cmd_item,
  output logic              res_valid,
  input  logic              res_stall,
  output rbd_pkg::rbd_res_t res_item,
  input  rbd_pkg::rbd_ctl_t ctl,
  output rbd_pkg::rbd_sts_t sts
);
  import rbd_pkg::*;

  rbd_cmd_t           item;
  logic [ADDR_W-1:0]  head;
  logic [COUNT_W-1:0] count;
  logic               reversed;
  logic               front_cmd;
  logic               at_front;
  logic [ADDR_W-1:0]  tail_off;
  logic [ADDR_W-1:0]  addr;
  logic [DATA_W-1:0]  rdata;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd_item;
    end
  end

  always_comb begin
    sts.is_push  = 1'b0;
    sts.is_pop   = 1'b0;
    sts.is_rev   = 1'b0;
    sts.full     = (count == COUNT_W'(CAPACITY));
    sts.empty    = (count == '0);
    sts.out_free = !res_valid || !res_stall;
    unique case (item.command) inside
      CMD_PUSH_BACK, CMD_PUSH_FRONT: sts.is_push = 1'b1;
      CMD_POP_FRONT, CMD_POP_BACK:   sts.is_pop  = 1'b1;
      CMD_REVERSE:                   sts.is_rev  = 1'b1;
      default: ;
    endcase
  end

  assign front_cmd = (item.command == CMD_PUSH_FRONT) || (item.command == CMD_POP_FRONT);
  assign at_front  = front_cmd ^ reversed;
  assign tail_off  = ctl.exec_push ? count[ADDR_W-1:0] : count[ADDR_W-1:0] - ADDR_W'(1);

  always_comb begin
    if (at_front) begin
      addr = ctl.exec_push ? head - ADDR_W'(1) : head;
    end else begin
      addr = head + tail_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else begin
      if (ctl.exec_rev) begin
        reversed <= !reversed;
      end
      if (ctl.exec_push) begin
        count <= count + COUNT_W'(1);
        if (at_front) begin
          head <= head - ADDR_W'(1);
        end
      end
      if (ctl.exec_pop) begin
        count <= count - COUNT_W'(1);
        if (at_front) begin
          head <= head + ADDR_W'(1);
        end
      end
    end
  end

  rbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .en    (ctl.exec_push || ctl.exec_pop),
    .we    (ctl.exec_push),
    .addr  (addr),
    .wdata (item.push_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_status || ctl.load_data) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_status) begin
      res_item.status       <= sts.is_push ? ST_FULL : ST_EMPTY;
      res_item.popped_value <= '0;
    end else if (ctl.load_data) begin
      res_item.status       <= ST_OK;
      res_item.popped_value <= rdata;
    end
  end

endmodule

/* rtl/core/reversible_bounded_deque.sv */
// ----------------------------------------------------------------------------
// reversible_bounded_deque
// Bounded double-ended queue of signed 32-bit values with O(1) reverse.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd_item) takes one command a beat:
//   push back, push front, pop front, pop back or reverse. Unused codes
//   are dropped without a result.
//   res channel (res_valid/res_stall/res_item) returns one beat for a pop
//   (value or empty status) and for a push into a full queue.
//   Successful pushes and reverses return nothing.
// Timing:
//   A beat is taken only in the idle state. Push, reverse, unused codes and
//   full/empty rejects go from idle through the execute state; a successful
//   pop also passes the read state, for the registered read of the single-port
//   entry RAM. A reject result is loaded from the execute state and a popped
//   value from the read state, each once the output register is free.
// Reset clears head, count and reverse flag; the entry RAM is not cleared.
// A result held by res_stall sits in the output register; the next command
// is still taken, and it waits only if it has a result of its own to post.
// ----------------------------------------------------------------------------
module reversible_bounded_deque (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  rbd_pkg::rbd_cmd_t cmd_item,
  output logic              res_valid,
  input  logic              res_stall,
  output rbd_pkg::rbd_res_t res_item
);
  import rbd_pkg::*;

  rbd_ctl_t ctl;
  rbd_sts_t sts;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  rbd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

/* rtl/core/rbd_checker.sv */
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks for the reversible bounded deque.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input rbd_pkg::rbd_cmd_t cmd_item,
  input logic              res_valid,
  input logic              res_stall,
  input rbd_pkg::rbd_res_t res_item
);
  import rbd_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.status == ST_OK) || (res_item.status == ST_FULL) ||
                  (res_item.status == ST_EMPTY))
    else $error("illegal result status");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.status != ST_OK) |-> res_item.popped_value == '0)
    else $error("reject beat carries nonzero value");

  a_reverse_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd_item.command == CMD_REVERSE)
      |=> ##1 !$rose(res_valid))
    else $error("reverse produced a result");

endmodule

bind reversible_bounded_deque rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_item  (cmd_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

/* verif/rbd_checker.sv */
// ----------------------------------------------------------------------------
// rbd_scoreboard
// Watches both channels of the reversible bounded deque. It keeps a mirror
// of the deque contents and the reverse flag, predicts the result beat, if
// any, for every accepted command, and compares each result beat in order.
// ----------------------------------------------------------------------------
module rbd_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  rbd_pkg::rbd_cmd_t cmd_item,
  input  logic              res_valid,
  input  logic              res_stall,
  input  rbd_pkg::rbd_res_t res_item,
  output int                mismatches,
  output int                owed,
  output int                values_popped,
  output int                full_rejects,
  output int                empty_rejects
);
  import rbd_pkg::*;

  logic signed [DATA_W-1:0] mirror_values[$];
  rbd_res_t                 owed_results[$];
  logic                     flipped;
  bit                       produces;
  rbd_res_t                 predicted;
  rbd_res_t                 oldest;

  initial begin
    mismatches    = 0;
    owed          = 0;
    values_popped = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    flipped       = 1'b0;
  end

  // Logical deque: the flag picks which end of the mirror a command touches.
  task automatic apply_command(input rbd_cmd_t c, output bit has_res, output rbd_res_t r);
    bit at_head;
    has_res = 1'b0;
    r       = '0;
    case (c.command) inside
      CMD_REVERSE: flipped = ~flipped;
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (mirror_values.size() >= CAPACITY) begin
          has_res  = 1'b1;
          r.status = ST_FULL;
        end else begin
          at_head = (c.command == CMD_PUSH_FRONT) ^ flipped;
          if (at_head) mirror_values.push_front(c.push_value);
          else mirror_values.insert(mirror_values.size(), c.push_value);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        has_res = 1'b1;
        if (mirror_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          at_head  = (c.command == CMD_POP_FRONT) ^ flipped;
          r.popped_value = at_head ? mirror_values.pop_front() : mirror_values.pop_back();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mirror_values.delete();
      owed_results.delete();
      flipped = 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        apply_command(cmd_item, produces, predicted);
        if (produces) owed_results.insert(owed_results.size(), predicted);
      end
      if (res_valid && !res_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: status %0d popped_value %0d",
                 res_item.status, res_item.popped_value);
          mismatches++;
        end else begin
          oldest = owed_results.pop_front();
          case (oldest.status)
            ST_OK:   values_popped++;
            ST_FULL: full_rejects++;
            default: empty_rejects++;
          endcase
          if (res_item.status !== oldest.status) begin
            $error("status mismatch: expected %0d, got %0d", oldest.status, res_item.status);
            mismatches++;
          end
          if (res_item.popped_value !== oldest.popped_value) begin
            $error("popped_value mismatch: expected %0d, got %0d",
                   oldest.popped_value, res_item.popped_value);
            mismatches++;
          end
        end
      end
    end
    owed = owed_results.size();
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the reversible bounded deque with directed corner commands, a long
// random mix of pushes, pops and reverses around a moving fill target, and a
// closing stretch with no idling. Both sides idle in random bursts before
// that; rbd_scoreboard predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import rbd_pkg::*;

  localparam int         LIMIT          = 1_000_000;
  localparam int         RANDOM_BEATS   = 1000;
  localparam int         QUIET_BEATS    = 180;
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  rbd_cmd_t cmd_item  = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  rbd_res_t res_item;

  int mismatches, owed, values_popped, full_rejects, empty_rejects;
  int cycles     = 0;
  int sent       = 0;
  int fill       = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;
  bit send_calm  = 1'b0;
  bit recv_calm  = 1'b0;

  reversible_bounded_deque dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  rbd_scoreboard scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd_item      (cmd_item),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_item      (res_item),
    .mismatches    (mismatches),
    .owed          (owed),
    .values_popped (values_popped),
    .full_rejects  (full_rejects),
    .empty_rejects (empty_rejects)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 149) == 0) recv_calm = ~recv_calm;
      if (stall_left == 0 && !recv_calm && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 12);
    end
    res_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return -1;
      3:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input logic [2:0] code, input logic signed [DATA_W-1:0] value);
    int gap;
    cmd_item  <= '{command: code, push_value: value};
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    sent++;
    case (code) inside
      CMD_PUSH_BACK, CMD_PUSH_FRONT: if (fill < CAPACITY) fill++;
      CMD_POP_FRONT, CMD_POP_BACK:   if (fill > 0) fill--;
      default: ;
    endcase
    if ($urandom_range(0, 99) == 0) send_calm = ~send_calm;
    if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed result beat has come back
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
    @(posedge clk);
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  initial begin
    int         roll;
    int         target;
    logic [2:0] code;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pops, extremes at both ends, reverse, unused codes
    send(CMD_POP_FRONT, VAL_MAX);
    send(CMD_POP_BACK, VAL_MIN);
    send(CMD_PUSH_BACK, VAL_MAX);
    send(CMD_PUSH_FRONT, VAL_MIN);
    send(CMD_PUSH_BACK, -1);
    send(CMD_PUSH_FRONT, 0);
    send(CMD_REVERSE, VAL_MAX);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_UNUSED_LO, VAL_MAX);
    send(CMD_UNUSED_MID, -1);
    send(CMD_UNUSED_HI, VAL_MIN);
    send(CMD_PUSH_FRONT, 32'sh5555_5555);
    send(CMD_PUSH_BACK, 32'shAAAA_AAAA);
    send(CMD_REVERSE, 0);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_REVERSE, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_REVERSE, 0);

    target = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) target = $urandom_range(0, 48);
      if (i == RANDOM_BEATS / 2) drain();
      roll = $urandom_range(0, 99);
      if (roll < 3) code = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if (roll < 12) code = CMD_REVERSE;
      else if ((fill < target) ? (roll < 75) : (roll < 40)) code = any_push();
      else code = any_pop();
      send(code, pick_value());
    end

    // closing stretch with no idling on either side
    drain();
    quiet = 1'b1;
    repeat (QUIET_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) code = CMD_REVERSE;
      else if (roll < 55) code = any_push();
      else code = any_pop();
      send(code, pick_value());
    end

    drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    $display("%0d commands sent; %0d values popped, %0d pops from an empty deque,",
             sent, values_popped, empty_rejects);
    $display("%0d pushes into a full deque; reverses, unused codes and stalls mixed in",
             full_rejects);
    if (mismatches == 0 && owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
